>>> rtl/sfv_pkg.sv
`default_nettype none

package sfv_pkg;

  localparam int unsigned CountW = 4;

  localparam logic [CountW-1:0] StemMax  = 4'd8;
  localparam logic [CountW-1:0] ExtMax   = 4'd3;
  localparam logic [CountW-1:0] NameMax  = 4'd12;
  localparam logic [CountW-1:0] CountSat = 4'd15;
  localparam logic [CountW-1:0] PrefixLen = 4'd4;
  localparam logic [CountW-1:0] ShortDevLen = 4'd3;

  localparam logic [7:0] ChCtrlTop = 8'h20;
  localparam logic [7:0] ChDel     = 8'h7f;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7a;
  localparam logic [7:0] ChDigit1  = 8'h31;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] CaseBit   = 8'h20;

  // reserved device stems, first byte in the low lane
  localparam logic [31:0] DevCon = 32'h004e4f43;
  localparam logic [31:0] DevPrn = 32'h004e5250;
  localparam logic [31:0] DevAux = 32'h00585541;
  localparam logic [31:0] DevNul = 32'h004c554e;
  localparam logic [23:0] DevCom = 24'h4d4f43;
  localparam logic [23:0] DevLpt = 24'h54504c;

  typedef struct packed {
    logic       is_dot;
    logic       is_space;
    logic       forbidden;
    logic [7:0] upper;
  } char_class_t;

  function automatic logic fat_illegal(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c)
      8'h20, 8'h22, 8'h2a, 8'h2b, 8'h2c, 8'h2f,
      8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
      8'h5b, 8'h5c, 8'h5d, 8'h7c: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountSat) ? v : v + 4'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sfv_char_class.sv
`default_nettype none

module sfv_char_class (
  input  wire logic [7:0]          char_code_i,
  output sfv_pkg::char_class_t     class_o
);

  logic lower;

  assign lower = (char_code_i >= sfv_pkg::ChLowerA) && (char_code_i <= sfv_pkg::ChLowerZ);

  always_comb begin
    class_o.is_dot    = (char_code_i == sfv_pkg::ChDot);
    class_o.is_space  = (char_code_i == sfv_pkg::ChSpace);
    class_o.forbidden = (char_code_i < sfv_pkg::ChCtrlTop) ||
                        (char_code_i == sfv_pkg::ChDel) ||
                        char_code_i[7] ||
                        sfv_pkg::fat_illegal(char_code_i);
    class_o.upper     = lower ? (char_code_i & ~sfv_pkg::CaseBit) : char_code_i;
  end

endmodule

`default_nettype wire

>>> rtl/short_filename_validator.sv
`default_nettype none

// DOS 8.3 short file name checker. A name arrives one byte per word, the last
// byte flagged by final_byte_i; one verdict word (rejected_o) follows that byte,
// none for the others. One byte is taken every clock: the checks and the small
// saturating counters sit between the name state registers and the verdict
// register. While a verdict waits on the output and out_ready_i is low, no new
// byte is taken; out_ready_i feeds in_ready_o directly, so a verdict taken in a
// cycle frees the input in that same cycle.
// The verdict is registered and appears in the cycle after the final byte is
// taken. State clears after each verdict.
module short_filename_validator (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       final_byte_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic       rejected_o
);

  logic [sfv_pkg::CountW-1:0] byte_position_q, byte_position_d;
  logic [sfv_pkg::CountW-1:0] stem_length_q, stem_length_d;
  logic [sfv_pkg::CountW-1:0] extension_length_q, extension_length_d;
  logic                       dot_seen_q, dot_seen_d;
  logic                       bad_seen_q, bad_seen_d;
  logic [31:0]                stem_prefix_q, stem_prefix_d;
  logic                       out_valid_q, out_valid_d;
  logic                       rejected_q, rejected_d;

  sfv_pkg::char_class_t cls;
  logic in_fire;
  logic reserved;
  logic verdict;

  sfv_char_class u_class (
    .char_code_i (char_code_i),
    .class_o     (cls)
  );

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign rejected_o  = rejected_q;

  always_comb begin
    stem_length_d      = stem_length_q;
    extension_length_d = extension_length_q;
    dot_seen_d         = dot_seen_q;
    bad_seen_d         = bad_seen_q;
    stem_prefix_d      = stem_prefix_q;
    if (cls.is_dot) begin
      if (dot_seen_q || (byte_position_q == '0)) begin
        bad_seen_d = 1'b1;
      end
      dot_seen_d = 1'b1;
    end else begin
      if (cls.forbidden) begin
        bad_seen_d = 1'b1;
      end
      if (dot_seen_q) begin
        extension_length_d = sfv_pkg::sat_inc(extension_length_q);
      end else begin
        if (stem_length_q < sfv_pkg::PrefixLen) begin
          stem_prefix_d = stem_prefix_q |
                          ({24'd0, cls.upper} << {stem_length_q[1:0], 3'b000});
        end
        stem_length_d = sfv_pkg::sat_inc(stem_length_q);
      end
    end
    byte_position_d = sfv_pkg::sat_inc(byte_position_q);
  end

  always_comb begin
    reserved = 1'b0;
    if (stem_length_d == sfv_pkg::ShortDevLen) begin
      reserved = (stem_prefix_d == sfv_pkg::DevCon) || (stem_prefix_d == sfv_pkg::DevPrn) ||
                 (stem_prefix_d == sfv_pkg::DevAux) || (stem_prefix_d == sfv_pkg::DevNul);
    end else if (stem_length_d == sfv_pkg::PrefixLen) begin
      reserved = (stem_prefix_d[31:24] >= sfv_pkg::ChDigit1) &&
                 (stem_prefix_d[31:24] <= sfv_pkg::ChDigit9) &&
                 ((stem_prefix_d[23:0] == sfv_pkg::DevCom) ||
                  (stem_prefix_d[23:0] == sfv_pkg::DevLpt));
    end
  end

  assign verdict = bad_seen_d ||
                   (byte_position_d > sfv_pkg::NameMax) ||
                   cls.is_dot || cls.is_space ||
                   (stem_length_d == '0) ||
                   (stem_length_d > sfv_pkg::StemMax) ||
                   (extension_length_d > sfv_pkg::ExtMax) ||
                   reserved;

  always_comb begin
    out_valid_d = out_valid_q;
    rejected_d  = rejected_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && final_byte_i) begin
      out_valid_d = 1'b1;
      rejected_d  = verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q    <= '0;
      stem_length_q      <= '0;
      extension_length_q <= '0;
      dot_seen_q         <= 1'b0;
      bad_seen_q         <= 1'b0;
      stem_prefix_q      <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        if (final_byte_i) begin
          byte_position_q    <= '0;
          stem_length_q      <= '0;
          extension_length_q <= '0;
          dot_seen_q         <= 1'b0;
          bad_seen_q         <= 1'b0;
          stem_prefix_q      <= '0;
        end else begin
          byte_position_q    <= byte_position_d;
          stem_length_q      <= stem_length_d;
          extension_length_q <= extension_length_d;
          dot_seen_q         <= dot_seen_d;
          bad_seen_q         <= bad_seen_d;
          stem_prefix_q      <= stem_prefix_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rejected_q <= rejected_d;
  end

`ifndef ASSERT_OFF
  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && final_byte_i |=> (byte_position_q == '0) && !dot_seen_q && !bad_seen_q)
    else $error("name state not cleared after final byte");

  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && final_byte_i))
    else $error("verdict word without a final byte");

  a_ext_needs_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (extension_length_q != '0) |-> dot_seen_q)
    else $error("extension counted without a dot");

  a_stem_within_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stem_length_q <= byte_position_q)
    else $error("stem longer than name");

  a_held_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(rejected_q))
    else $error("stalled verdict word lost");
`endif

endmodule

`default_nettype wire

>>> tb/sv/short_filename_validator_tb.sv
`default_nettype none

module short_filename_validator_tb;

  localparam int unsigned RandomBytes = 950;
  localparam int unsigned IdleLimit   = 500;
  localparam int unsigned DrainCycles = 4;

  typedef enum int unsigned {
    FlawIllegal,
    FlawLeadDot,
    FlawTrailDot,
    FlawTrailSpace,
    FlawSecondDot,
    FlawLongStem,
    FlawLongExt,
    FlawOverlong
  } name_flaw_e;

  // predicts one verdict per name and holds it until the block answers
  class verdict_board;
    logic [sfv_pkg::CountW-1:0] seen_len;
    logic [sfv_pkg::CountW-1:0] stem_count;
    logic [sfv_pkg::CountW-1:0] ext_len;
    logic                       dot_seen;
    logic                       bad_seen;
    logic [31:0]                stem_head;
    logic                       expected_verdicts[$];
    int                         mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      seen_len   = '0;
      stem_count = '0;
      ext_len    = '0;
      dot_seen   = 1'b0;
      bad_seen   = 1'b0;
      stem_head  = '0;
    endfunction

    function logic [sfv_pkg::CountW-1:0] bump(input logic [sfv_pkg::CountW-1:0] v);
      return (v == sfv_pkg::CountSat) ? v : v + 1'b1;
    endfunction

    function bit unsafe_byte(input logic [7:0] c);
      return c < 8'h20 || c >= 8'h7f ||
             c inside {8'h20, 8'h22, 8'h2a, 8'h2b, 8'h2c, 8'h2f, 8'h3a, 8'h3b,
                       8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h5b, 8'h5c, 8'h5d, 8'h7c};
    endfunction

    function bit device_stem();
      if (stem_count == 4'd3)
        return stem_head == sfv_pkg::DevCon || stem_head == sfv_pkg::DevPrn ||
               stem_head == sfv_pkg::DevAux || stem_head == sfv_pkg::DevNul;
      if (stem_count == 4'd4 && stem_head[31:24] >= sfv_pkg::ChDigit1 &&
          stem_head[31:24] <= sfv_pkg::ChDigit9)
        return stem_head[23:0] == sfv_pkg::DevCom || stem_head[23:0] == sfv_pkg::DevLpt;
      return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] c, input logic last);
      logic [7:0] up;
      logic       rej;
      if (c == sfv_pkg::ChDot) begin
        if (dot_seen || seen_len == 0) bad_seen = 1'b1;
        dot_seen = 1'b1;
      end else begin
        if (unsafe_byte(c)) bad_seen = 1'b1;
        if (dot_seen) begin
          ext_len = bump(ext_len);
        end else begin
          if (stem_count < 4) begin
            up = (c >= sfv_pkg::ChLowerA && c <= sfv_pkg::ChLowerZ) ?
                 (c & ~sfv_pkg::CaseBit) : c;
            stem_head[8*stem_count +: 8] = up;
          end
          stem_count = bump(stem_count);
        end
      end
      seen_len = bump(seen_len);
      if (last) begin
        rej = bad_seen || seen_len > sfv_pkg::NameMax || c == sfv_pkg::ChDot ||
              c == sfv_pkg::ChSpace || stem_count == 0 || stem_count > sfv_pkg::StemMax ||
              ext_len > sfv_pkg::ExtMax || device_stem();
        expected_verdicts.push_back(rej);
        clear();
      end
    endfunction

    function void check_verdict(input logic got);
      logic want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict with none expected, expected none, actual rejected=%0b",
                 $time, got);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          $display("%0t: verdict mismatch, expected rejected=%0b, actual rejected=%0b",
                   $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [7:0] char_code_i  = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       rejected_o;

  verdict_board board;
  logic [7:0]   name_bytes[$];
  bit           calm = 1'b0;
  int           stall_left = 0;
  int           idle_cycles = 0;
  int unsigned  random_sent;

  short_filename_validator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .final_byte_i (final_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rejected_o   (rejected_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] legal_char();
    case ($urandom_range(0, 3))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return sfv_pkg::ChLowerA + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: begin
        case ($urandom_range(0, 7))
          0: return 8'h21;
          1: return 8'h23;
          2: return 8'h24;
          3: return 8'h27;
          4: return 8'h2d;
          5: return 8'h40;
          6: return 8'h5f;
          default: return 8'h7e;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] unsafe_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 31));
      1: return 8'h7f;
      2: return 8'($urandom_range(128, 255));
      default: begin
        case ($urandom_range(0, 15))
          0:  return 8'h20;
          1:  return 8'h22;
          2:  return 8'h2a;
          3:  return 8'h2b;
          4:  return 8'h2c;
          5:  return 8'h2f;
          6:  return 8'h3a;
          7:  return 8'h3b;
          8:  return 8'h3c;
          9:  return 8'h3d;
          10: return 8'h3e;
          11: return 8'h3f;
          12: return 8'h5b;
          13: return 8'h5c;
          14: return 8'h5d;
          default: return 8'h7c;
        endcase
      end
    endcase
  endfunction

  function automatic void load_text(input string s);
    name_bytes.delete();
    for (int i = 0; i < s.len(); i++) name_bytes.push_back(s[i]);
  endfunction

  function automatic void make_plain(input int stem_n, input int ext_n, input bit with_dot);
    name_bytes.delete();
    for (int i = 0; i < stem_n; i++) name_bytes.push_back(legal_char());
    if (with_dot) begin
      name_bytes.push_back(sfv_pkg::ChDot);
      for (int i = 0; i < ext_n; i++) name_bytes.push_back(legal_char());
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= c;
    final_byte_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_byte(c, last);
  endtask

  task automatic send_name();
    for (int i = 0; i < name_bytes.size(); i++)
      send_byte(name_bytes[i], i == name_bytes.size() - 1);
  endtask

  // sender holds off until every verdict is back
  task automatic drain_pause();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic random_name();
    int         r;
    int         idx;
    name_flaw_e flaw;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      make_plain($urandom_range(1, 8), $urandom_range(0, 3), 1'($urandom_range(0, 1)));
    end else if (r < 65) begin
      case ($urandom_range(0, 5))
        0: load_text("CON");
        1: load_text("PRN");
        2: load_text("AUX");
        3: load_text("NUL");
        4: load_text("COM");
        default: load_text("LPT");
      endcase
      if (name_bytes.size() == 3 && name_bytes[0] inside {8'h43, 8'h4c} &&
          name_bytes[1] inside {8'h4f, 8'h50})
        name_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
      for (int i = 0; i < name_bytes.size(); i++)
        if (name_bytes[i] >= 8'h41 && $urandom_range(0, 1)) name_bytes[i] |= sfv_pkg::CaseBit;
      if ($urandom_range(0, 4) == 0) name_bytes.push_back(legal_char());
      if ($urandom_range(0, 1)) begin
        name_bytes.push_back(sfv_pkg::ChDot);
        for (int i = $urandom_range(0, 3); i > 0; i--) name_bytes.push_back(legal_char());
      end
    end else if (r < 85) begin
      make_plain($urandom_range(1, 8), $urandom_range(1, 3), 1'($urandom_range(0, 1)));
      flaw = name_flaw_e'($urandom_range(0, 7));
      case (flaw)
        FlawIllegal: begin
          idx = $urandom_range(0, name_bytes.size() - 1);
          name_bytes[idx] = unsafe_char();
        end
        FlawLeadDot:    name_bytes.push_front(sfv_pkg::ChDot);
        FlawTrailDot:   name_bytes.push_back(sfv_pkg::ChDot);
        FlawTrailSpace: name_bytes.push_back(sfv_pkg::ChSpace);
        FlawSecondDot: begin
          idx = $urandom_range(0, name_bytes.size() - 1);
          name_bytes[idx] = sfv_pkg::ChDot;
          name_bytes.push_back(sfv_pkg::ChDot);
          name_bytes.push_back(legal_char());
        end
        FlawLongStem:   make_plain($urandom_range(9, 13), $urandom_range(0, 3),
                                   1'($urandom_range(0, 1)));
        FlawLongExt:    make_plain($urandom_range(1, 8), $urandom_range(4, 6), 1'b1);
        default:        make_plain($urandom_range(13, 20), 0, 1'b0);
      endcase
    end else begin
      name_bytes.delete();
      for (int i = $urandom_range(1, 18); i > 0; i--)
        name_bytes.push_back($urandom_range(0, 5) == 0 ? sfv_pkg::ChDot :
                             8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_verdict(rejected_o);
    if (calm || stall_left == 0) begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) stall_left <= pick_gap();
    end else begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("short_filename_validator regression: fail");
      $finish;
    end
  end

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_text("A");      send_name();
    load_text(".");      send_name();
    load_text("nul");    send_name();
    load_text("Com9");   send_name();
    name_bytes.delete(); name_bytes.push_back(8'h00); send_name();
    name_bytes.delete(); name_bytes.push_back(8'hff); send_name();
    load_text("AB.");    send_name();
    load_text("LPT1.C"); send_name();
    drain_pause();

    random_sent = 0;
    while (random_sent < RandomBytes) begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      random_name();
      send_name();
      random_sent += name_bytes.size();
      if ($urandom_range(0, 39) == 0) drain_pause();
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0)
      $display("short_filename_validator regression: pass");
    else
      $display("short_filename_validator regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/sfv_pkg.sv
rtl/sfv_char_class.sv
rtl/short_filename_validator.sv
tb/sv/short_filename_validator_tb.sv
